// ===== rtl/ylso_pkg.sv =====
// Shared types and constants for the oscillator lock search block.
// Used by ylso_predict and yig_lock_search_optimizer; depends on nothing.
`default_nettype none

package ylso_pkg;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 16;
	localparam int TOL_W       = 15;
	localparam int ITER_W      = 6;
	localparam int COUNT_W     = 11;
	localparam int TARGET_W    = 14;
	localparam int ERR_W       = 16;

	localparam int unsigned SEARCH_STEPS = 7;

	localparam logic [COUNT_W-1:0]  COUNT_MAX = 11'd2047;
	localparam logic [TARGET_W-1:0] FREQ_LOW  = 14'd8000;
	localparam logic [TARGET_W-1:0] FREQ_HIGH = 14'd12500;

	// ceil(2^37 / 4500): exact quotient for any 24-bit dividend.
	localparam logic [24:0] SPAN_RECIP       = 25'd30541990;
	localparam int          SPAN_RECIP_SHIFT = 37;

	localparam logic [TOL_W-1:0]  TOL_RESET  = 15'd655;
	localparam logic [ITER_W-1:0] ITER_RESET = 6'd30;

	localparam logic [0:0] REG_TOLERANCE = 1'b0;
	localparam logic [0:0] REG_MAX_ITER  = 1'b1;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_OBSERVE = 1'b1;

	typedef enum logic [1:0] {
		RUN_IDLE  = 2'd0,
		RUN_LOOP  = 2'd1,
		RUN_CHECK = 2'd2
	} run_state_t;

	typedef enum logic [1:0] {
		PHASE_IDLE     = 2'd0,
		PHASE_SEARCH   = 2'd1,
		PHASE_OPTIMIZE = 2'd2
	} lock_phase_t;

	typedef enum logic [2:0] {
		ST_STEPPING     = 3'd0,
		ST_LOOP_ENDED   = 3'd1,
		ST_LOCKED       = 3'd2,
		ST_FAILED       = 3'd3,
		ST_OUT_OF_RANGE = 3'd4,
		ST_IGNORED      = 3'd5
	} status_t;

	typedef struct packed {
		logic                in_range;
		logic [COUNT_W-1:0]  count;
	} pred_t;

	// Offsets tried around the predicted count while the loop is unlocked.
	function automatic logic signed [12:0] search_offset(input logic [2:0] idx);
		logic signed [12:0] off;
		case (idx)
			3'd0:    off = 13'sd50;
			3'd1:    off = -13'sd50;
			3'd2:    off = 13'sd100;
			3'd3:    off = -13'sd100;
			3'd4:    off = 13'sd150;
			3'd5:    off = -13'sd150;
			default: off = 13'sd0;
		endcase
		return off;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/yig_lock_search_optimizer.sv =====
// Oscillator lock search and trim: input stage, state update and result register.
// Depends on ylso_pkg and ylso_predict.
//
// One item enters per clock while the result register is empty or being taken;
// the item waits in the input register, and the result register takes the
// updated state when the item advances. A result held by the receiver keeps the
// item behind it in the input register and drops s_tready. The longest path is
// the reciprocal multiply of the target conversion. A start item outside
// 8000..12500 MHz reports out of range and one during a run is ignored; otherwise
// the predicted count is applied and the loop runs for up to max_iterations
// observations (zero counts as one), trimming by one count per locked observation
// or trying the next table offset per unlocked one, and ends early within
// tolerance, at a rail or past the table. The observation after the loop ends
// reports locked or failed.
`default_nettype none

module yig_lock_search_optimizer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// target_mhz[13:0], lock_bit[14], error_sample[30:15], zero[31]
	input  logic [ylso_pkg::IN_TDATA_W-1:0]  s_tdata,
	// command[0]
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// tune_counts[10:0], lock_phase[12:11], status[15:13]
	output logic [ylso_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [ylso_pkg::TOL_W-1:0]       cfg_data
);
	import ylso_pkg::*;

	logic [TOL_W-1:0]  tol_q;
	logic [ITER_W-1:0] iter_q;

	logic                 valid_s1;
	logic                 cmd_s1;
	logic [TARGET_W-1:0]  target_s1;
	logic                 lock_s1;
	logic [ERR_W-1:0]     err_s1;

	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	run_state_t        run_q, run_nxt;
	lock_phase_t       info_q, info_nxt;
	logic [COUNT_W-1:0] cur_q, cur_nxt;
	logic [COUNT_W-1:0] pred_q, pred_nxt;
	logic [2:0]        idx_q, idx_nxt;
	logic [ITER_W-1:0] steps_q, steps_nxt;
	status_t           status_d;
	logic [OUT_TDATA_W-1:0] result_d;

	pred_t              pred;
	logic               advance;
	logic               stop;
	logic               err_neg, err_pos;
	logic [16:0]        err_mag;
	logic signed [12:0] cur_sum;
	logic [COUNT_W-1:0] cur_clamped;
	logic [ITER_W-1:0]  steps_dec;

	ylso_predict u_predict (
		.target_mhz (target_s1),
		.pred       (pred)
	);

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= TOL_RESET;
			iter_q <= ITER_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_TOLERANCE) begin
				tol_q <= cfg_data;
			end else if (cfg_index == REG_MAX_ITER) begin
				iter_q <= cfg_data[ITER_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1    <= s_tuser;
			target_s1 <= s_tdata[13:0];
			lock_s1   <= s_tdata[14];
			err_s1    <= s_tdata[30:15];
		end
	end

	// Next state of the search loop for the item in the input register.
	always_comb begin
		run_nxt   = run_q;
		info_nxt  = info_q;
		cur_nxt   = cur_q;
		pred_nxt  = pred_q;
		idx_nxt   = idx_q;
		steps_nxt = steps_q;
		status_d  = ST_IGNORED;

		err_neg = err_s1[ERR_W-1];
		err_pos = !err_s1[ERR_W-1] && (err_s1 != '0);
		err_mag = err_neg ? (17'd0 - {1'b1, err_s1}) : {1'b0, err_s1};
		stop    = 1'b0;
		cur_sum = $signed({2'b00, cur_q});

		if (lock_s1) begin
			if ((err_mag < {2'b00, tol_q})
			    || (err_pos && (cur_q == COUNT_MAX))
			    || (err_neg && (cur_q == '0))) begin
				stop = 1'b1;
			end else if (err_pos) begin
				cur_sum = $signed({2'b00, cur_q}) + 13'sd1;
			end else begin
				cur_sum = $signed({2'b00, cur_q}) - 13'sd1;
			end
		end else if (idx_q < 3'(SEARCH_STEPS)) begin
			cur_sum = $signed({2'b00, pred_q}) + search_offset(idx_q);
		end else begin
			stop = 1'b1;
		end

		if (cur_sum < 13'sd0) begin
			cur_clamped = '0;
		end else if (cur_sum > $signed({2'b00, COUNT_MAX})) begin
			cur_clamped = COUNT_MAX;
		end else begin
			cur_clamped = cur_sum[COUNT_W-1:0];
		end
		steps_dec = (steps_q != '0) ? steps_q - 6'd1 : steps_q;

		unique case (run_q)
			RUN_IDLE: begin
				if (cmd_s1 == CMD_START) begin
					if (!pred.in_range) begin
						status_d = ST_OUT_OF_RANGE;
					end else begin
						pred_nxt  = pred.count;
						cur_nxt   = pred.count;
						idx_nxt   = '0;
						steps_nxt = (iter_q == '0) ? 6'd1 : iter_q;
						run_nxt   = RUN_LOOP;
						info_nxt  = PHASE_SEARCH;
						status_d  = ST_STEPPING;
					end
				end
			end
			RUN_LOOP: begin
				if (cmd_s1 == CMD_OBSERVE) begin
					if (lock_s1) begin
						info_nxt = PHASE_OPTIMIZE;
					end else if (!stop) begin
						idx_nxt = idx_q + 3'd1;
					end
					cur_nxt   = cur_clamped;
					steps_nxt = steps_dec;
					if (stop || (steps_dec == '0)) begin
						run_nxt  = RUN_CHECK;
						status_d = ST_LOOP_ENDED;
					end else begin
						status_d = ST_STEPPING;
					end
				end
			end
			RUN_CHECK: begin
				if (cmd_s1 == CMD_OBSERVE) begin
					run_nxt  = RUN_IDLE;
					info_nxt = PHASE_IDLE;
					status_d = lock_s1 ? ST_LOCKED : ST_FAILED;
				end
			end
			default: begin
				run_nxt = RUN_IDLE;
			end
		endcase
	end

	// Result word shows the state after the update.
	always_comb begin
		result_d = {status_d, info_nxt, cur_nxt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			run_q     <= RUN_IDLE;
			info_q    <= PHASE_IDLE;
			cur_q     <= '0;
			pred_q    <= '0;
			idx_q     <= '0;
			steps_q   <= '0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
			run_q     <= run_nxt;
			info_q    <= info_nxt;
			cur_q     <= cur_nxt;
			pred_q    <= pred_nxt;
			idx_q     <= idx_nxt;
			steps_q   <= steps_nxt;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= result_d;
		end
	end

	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q == RUN_IDLE) |-> (info_q == PHASE_IDLE))
		else $error("idle loop with a non-idle lock phase");

	a_loop_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q == RUN_LOOP) |-> (steps_q != '0))
		else $error("loop running with no steps left");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 3'(SEARCH_STEPS))
		else $error("search index past the offset table");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(target_s1) && $stable(err_s1)))
		else $error("stalled item lost from the input register");

endmodule

`default_nettype wire

// ===== rtl/ylso_predict.sv =====
// Range check of a target frequency and its conversion to a tuning count.
// Depends on ylso_pkg.
`default_nettype none

module ylso_predict (
	input  logic [ylso_pkg::TARGET_W-1:0] target_mhz,
	output ylso_pkg::pred_t               pred
);
	import ylso_pkg::*;

	logic [TARGET_W-1:0] diff;
	logic [23:0]         scaled;
	logic [48:0]         product;

	// count = (target - 8000) * 2047 / 4500, the division done as an exact
	// multiply by a reciprocal and a shift.
	always_comb begin
		diff    = target_mhz - FREQ_LOW;
		scaled  = {diff[12:0], 11'd0} - {11'd0, diff[12:0]};
		product = {25'd0, scaled} * {24'd0, SPAN_RECIP};
		pred.in_range = (target_mhz >= FREQ_LOW) && (target_mhz <= FREQ_HIGH);
		pred.count    = product[SPAN_RECIP_SHIFT +: COUNT_W];
	end

endmodule

`default_nettype wire

// ===== dv/lock_search_checker.sv =====
// Checker for the oscillator lock search block: watches the input, result and
// register channels, predicts every result and compares it field by field.
// Depends on ylso_pkg for widths, codes and reset values.
`default_nettype none

module lock_search_checker
	import ylso_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                   s_tuser,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	input  wire logic                   cfg_valid,
	input  wire logic                   cfg_ready,
	input  wire logic                   cfg_index,
	input  wire logic [TOL_W-1:0]       cfg_data,
	output int                          errors,
	output int                          pending,
	output int                          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// Same layout as m_tdata, status in the top bits.
	typedef struct packed {
		status_t             status;
		lock_phase_t         lock_phase;
		logic [COUNT_W-1:0]  tune_counts;
	} tune_result_t;

	localparam int PROBE_OFFSETS [0:6] = '{50, -50, 100, -100, 150, -150, 0};

	logic [TOL_W-1:0]   tolerance;
	logic [ITER_W-1:0]  iter_limit;
	logic [COUNT_W-1:0] cur_count;
	logic [COUNT_W-1:0] pred_count;
	int                 probe_idx;
	logic [ITER_W-1:0]  steps;
	run_state_t         run_st;
	lock_phase_t        shown_phase;

	tune_result_t expected_tunes[$];
	tune_result_t seen;
	tune_result_t want;

	function automatic tune_result_t advance_lock(input logic cmd, input logic [TARGET_W-1:0] tgt,
		input logic locked, input logic signed [ERR_W-1:0] err);
		tune_result_t r;
		int cur;
		int e;
		int mag;
		logic stop;
		stop = 1'b0;
		r.status = ST_IGNORED;
		e = int'(err);
		if (cmd == CMD_START) begin
			if (run_st != RUN_IDLE) begin
				r.status = ST_IGNORED;
			end else if (tgt < FREQ_LOW || tgt > FREQ_HIGH) begin
				r.status = ST_OUT_OF_RANGE;
			end else begin
				pred_count = COUNT_W'((int'(tgt) - int'(FREQ_LOW)) * int'(COUNT_MAX) / 4500);
				cur_count = pred_count;
				probe_idx = 0;
				steps = (iter_limit == '0) ? ITER_W'(1) : iter_limit;
				run_st = RUN_LOOP;
				shown_phase = PHASE_SEARCH;
				r.status = ST_STEPPING;
			end
		end else if (run_st == RUN_LOOP) begin
			cur = int'(cur_count);
			if (locked) begin
				mag = (e < 0) ? -e : e;
				shown_phase = PHASE_OPTIMIZE;
				if (mag < int'(tolerance) || (e > 0 && cur == int'(COUNT_MAX)) || (e < 0 && cur == 0))
					stop = 1'b1;
				else if (e > 0)
					cur++;
				else
					cur--;
			end else if (probe_idx < SEARCH_STEPS) begin
				cur = int'(pred_count) + PROBE_OFFSETS[probe_idx];
				probe_idx++;
			end else begin
				stop = 1'b1;
			end
			if (cur < 0)
				cur = 0;
			else if (cur > int'(COUNT_MAX))
				cur = int'(COUNT_MAX);
			cur_count = COUNT_W'(cur);
			if (steps != '0)
				steps--;
			if (stop || steps == '0) begin
				run_st = RUN_CHECK;
				r.status = ST_LOOP_ENDED;
			end else begin
				r.status = ST_STEPPING;
			end
		end else if (run_st == RUN_CHECK) begin
			run_st = RUN_IDLE;
			shown_phase = PHASE_IDLE;
			r.status = locked ? ST_LOCKED : ST_FAILED;
		end
		r.tune_counts = cur_count;
		r.lock_phase = shown_phase;
		return r;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance = TOL_RESET;
			iter_limit = ITER_RESET;
			cur_count = '0;
			pred_count = '0;
			probe_idx = 0;
			steps = '0;
			run_st = RUN_IDLE;
			shown_phase = PHASE_IDLE;
			expected_tunes.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TOLERANCE)
					tolerance = cfg_data;
				else
					iter_limit = cfg_data[ITER_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				seen = m_tdata;
				checked++;
				if (expected_tunes.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result with nothing expected: counts %0d phase %0d status %0d",
							$realtime, seen.tune_counts, seen.lock_phase, seen.status);
				end else begin
					want = expected_tunes.pop_front();
					if (seen !== want) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch: counts %0d/%0d phase %0d/%0d status %0d/%0d (exp/got)",
								$realtime, want.tune_counts, seen.tune_counts, want.lock_phase,
								seen.lock_phase, want.status, seen.status);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_tunes.push_back(advance_lock(s_tuser, s_tdata[TARGET_W-1:0],
					s_tdata[TARGET_W], s_tdata[TARGET_W+ERR_W:TARGET_W+1]));
			pending = expected_tunes.size();
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb_yig_lock_search_optimizer.sv =====
// Top of the lock search testbench: clock, reset, stimulus, flow control and verdict.
// Depends on ylso_pkg, yig_lock_search_optimizer and lock_search_checker.
`default_nettype none

module tb_yig_lock_search_optimizer;
	import ylso_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 385;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic                   cfg_index;
	logic [TOL_W-1:0]       cfg_data;

	int errors;
	int pending;
	int checked;

	int   idle_pct;
	int   stall_pct;
	logic hold_go;
	logic hold_off;
	int   items_sent;
	int   settings;
	int   cur_tol;
	int   cur_iter;

	yig_lock_search_optimizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lock_search_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
		end
	end

	// Long receiver hold-off so the block fills up and pushes back on its input.
	initial begin
		hold_off = 1'b0;
		wait (hold_go);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (300) @(negedge clk);
		hold_off <= 1'b0;
	end

	// Entered and left just after a falling edge; valid stays high between items
	// unless an idle gap is drawn.
	task automatic offer_item(input logic cmd, input logic [TARGET_W-1:0] tgt,
		input logic locked, input logic [ERR_W-1:0] err);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {1'b0, err, locked, tgt};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic start_at(input int tgt);
		offer_item(CMD_START, TARGET_W'(tgt), 1'($urandom_range(1)), ERR_W'($urandom_range(65535)));
	endtask

	task automatic observe(input logic locked, input logic [ERR_W-1:0] err);
		offer_item(CMD_OBSERVE, TARGET_W'($urandom_range(16383)), locked, err);
	endtask

	task automatic write_reg(input logic idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= TOL_W'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
		if (idx == REG_TOLERANCE)
			cur_tol = val;
		else
			cur_iter = val;
	endtask

	// Error samples: mostly outside the tolerance so trimming keeps going.
	function automatic logic [ERR_W-1:0] pick_error(input int small_pct);
		int mag;
		int v;
		if ($urandom_range(99) < small_pct) begin
			mag = (cur_tol > 0) ? $urandom_range(cur_tol - 1) : 0;
			v = $urandom_range(1) ? -mag : mag;
			return ERR_W'(v);
		end
		case ($urandom_range(5))
			0, 1: return ERR_W'($urandom_range(65535));
			2: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			default: begin
				mag = $urandom_range(32767, cur_tol);
				v = $urandom_range(1) ? -mag : mag;
				return ERR_W'(v);
			end
		endcase
	endfunction

	// One lock attempt: a start, a run of observations in a searching, trimming
	// or mixed style, and the final check.
	task automatic run_session();
		int n;
		int style;
		int tgt;
		logic locked;
		case ($urandom_range(9))
			0: tgt = $urandom_range(16383);
			1: tgt = $urandom_range(1) ? int'(FREQ_LOW) : int'(FREQ_HIGH);
			default: tgt = $urandom_range(int'(FREQ_HIGH), int'(FREQ_LOW));
		endcase
		start_at(tgt);
		style = $urandom_range(2);
		n = $urandom_range((cur_iter > 1) ? cur_iter : 1, 1);
		if (style == 0 && n > SEARCH_STEPS + 1)
			n = SEARCH_STEPS + 1;
		repeat (n) begin
			case (style)
				0: locked = ($urandom_range(9) == 0);
				1: locked = ($urandom_range(9) != 0);
				default: locked = 1'($urandom_range(1));
			endcase
			observe(locked, pick_error((style == 1) ? 6 : 20));
		end
		observe(1'($urandom_range(1)), pick_error(20));
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_go = 1'b0;
		items_sent = 0;
		settings = 1;
		cur_tol = int'(TOL_RESET);
		cur_iter = int'(ITER_RESET);
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset settings.
		observe(1'b1, 16'h0100);
		start_at(int'(FREQ_LOW) - 1);
		start_at(int'(FREQ_HIGH) + 1);
		start_at(0);
		start_at(16383);
		// Bottom rail: locked with a negative error ends the loop at count zero.
		start_at(int'(FREQ_LOW));
		observe(1'b1, 16'h8000);
		start_at(10000);
		observe(1'b1, 16'h0000);
		// Top rail, then a failed check.
		start_at(int'(FREQ_HIGH));
		observe(1'b1, 16'h7FFF);
		observe(1'b0, 16'hFFFF);
		// Unlocked search through the whole offset table, clamped at zero.
		start_at(int'(FREQ_LOW));
		repeat (SEARCH_STEPS + 1) observe(1'b0, 16'h5555);
		observe(1'b0, 16'hAAAA);

		for (int ph = 0; ph < 4; ph++) begin
			s_tvalid <= 1'b0;
			wait (pending == 0);
			@(negedge clk);
			case (ph)
				0: begin
					write_reg(REG_TOLERANCE, 0);
					write_reg(REG_MAX_ITER, 63);
					idle_pct = 0;
					stall_pct = 0;
					hold_go = 1'b1;
				end
				1: begin
					write_reg(REG_TOLERANCE, 32767);
					write_reg(REG_MAX_ITER, 1);
					idle_pct = 68;
					stall_pct = 0;
				end
				2: begin
					// An iteration limit of zero behaves as one.
					write_reg(REG_TOLERANCE, 1200);
					write_reg(REG_MAX_ITER, 0);
					idle_pct = 0;
					stall_pct = 68;
				end
				default: begin
					write_reg(REG_TOLERANCE, $urandom_range(3000, 100));
					write_reg(REG_MAX_ITER, $urandom_range(40, 2));
					idle_pct = 38;
					stall_pct = 38;
				end
			endcase
			settings++;
			while (items_sent < 22 + (ph + 1) * PHASE_ITEMS)
				run_session();
		end
		s_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (20) @(negedge clk);
		$display("summary: %0d items sent and %0d results checked over %0d register settings,",
			items_sent, checked, settings);
		$display("summary: four flow-control phases including a long output hold-off");
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
